// File: rtl/core/keyed_record_table_defines.svh
// Assertion macros used by the record table checker.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define KRT_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define KRT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/core/krt_pkg.sv
// Types and codes shared by the keyed record table modules.
package krt_pkg;

   localparam int OP_W    = 3;
   localparam int ENTRY_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_SEARCH = 3'd1,
      OP_UPDATE = 3'd2,
      OP_DELETE = 3'd3,
      OP_DUMP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DUP  = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        name;
      logic [15:0]        party;
      logic [63:0]        time_head;
      logic [7:0]         time_tail;
   } record_type;

endpackage

// File: rtl/core/krt_store.sv
// Record memory: one write port, one read port with registered read data.
module krt_store #(
   parameter int TABLE_DEPTH = 32,
   parameter int IDX_W       = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  krt_pkg::record_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output krt_pkg::record_type rd_data
);
   import krt_pkg::*;

   record_type mem [TABLE_DEPTH];
   record_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data valid the cycle after the address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/krt_seq.sv
// Request sequencer: walks the table one entry a cycle through the shared key compare.
module krt_seq #(
   parameter int TABLE_DEPTH = 32,
   parameter int IDX_W       = 5,
   parameter int CNT_W       = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [krt_pkg::OP_W-1:0]      req_op,
   input  krt_pkg::record_type           req_rec,
   output logic                          mem_wr_en,
   output logic [IDX_W-1:0]              mem_wr_addr,
   output krt_pkg::record_type           mem_wr_data,
   output logic                          mem_rd_en,
   output logic [IDX_W-1:0]              mem_rd_addr,
   input  krt_pkg::record_type           mem_rd_data,
   output logic                          rsp_strobe,
   output krt_pkg::status_type           rsp_status,
   output krt_pkg::record_type           rsp_rec,
   output logic [krt_pkg::ENTRY_W-1:0]   rsp_count,
   output logic                          rsp_last
);
   import krt_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DUMP
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   record_type           req_ff, req_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     iss_ff, iss_in;     // next address to read
   logic                 pend_ff, pend_in;   // read data arrives this cycle
   logic [CNT_W-1:0]     pidx_ff, pidx_in;   // address of the arriving data
   logic                 rsp_strobe_ff, rsp_strobe_in;
   status_type           rsp_status_ff, rsp_status_in;
   record_type           rsp_rec_ff, rsp_rec_in;
   logic [ENTRY_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 hit;
   logic                 at_last;
   logic [CNT_W-1:0]     shift_dst;
   logic [CNT_W-1:0]     next_idx;

   assign hit       = pend_ff && (mem_rd_data.key == req_ff.key);
   assign at_last   = (pidx_ff == count_ff - ONE_C);
   assign shift_dst = pidx_ff - ONE_C;
   assign next_idx  = pidx_ff + ONE_C;

   // next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pidx_in       = iss_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = 1'b1;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = iss_ff[IDX_W-1:0];
      mem_wr_data   = req_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = iss_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_op);
               req_in = req_rec;
               iss_in = '0;
               case (op_type'(req_op))
                  OP_INSERT: begin
                     if (count_ff >= DEPTH_C) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_rec_in    = '0;
                     end else if (count_ff == '0) begin
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = '0;
                        mem_wr_data   = req_rec;
                        count_in      = ONE_C;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_rec_in    = req_rec;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_SEARCH, OP_UPDATE, OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_MISS;
                        rsp_rec_in    = '0;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_rec_in    = '0;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // key lookup, one compare a cycle
         S_SCAN: begin
            mem_rd_en = (iss_ff < count_ff);
            if (mem_rd_en) begin
               iss_in = iss_ff + ONE_C;
            end
            pend_in = mem_rd_en;
            if (hit) begin
               pend_in       = 1'b0;
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_rec_in    = mem_rd_data;
               case (op_ff)
                  OP_INSERT: begin
                     rsp_status_in = ST_DUP;
                     rsp_rec_in    = '0;
                  end
                  OP_UPDATE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pidx_ff[IDX_W-1:0];
                     rsp_rec_in  = req_ff;
                  end
                  OP_DELETE: begin
                     count_in = count_ff - ONE_C;
                     if (next_idx < count_ff) begin
                        state_in = S_SHIFT;
                        iss_in   = next_idx;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (pend_ff && at_last) begin
               pend_in       = 1'b0;
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               case (op_ff)
                  OP_INSERT: begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = count_ff[IDX_W-1:0];
                     count_in      = count_ff + ONE_C;
                     rsp_status_in = ST_OK;
                     rsp_rec_in    = req_ff;
                  end
                  default: begin
                     rsp_status_in = ST_MISS;
                     rsp_rec_in    = '0;
                  end
               endcase
            end
         end

         // close the gap after a delete: entry i+1 moves to i
         S_SHIFT: begin
            mem_rd_en = (iss_ff <= count_ff);
            if (mem_rd_en) begin
               iss_in = iss_ff + ONE_C;
            end
            pend_in = mem_rd_en;
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = shift_dst[IDX_W-1:0];
               mem_wr_data = mem_rd_data;
            end
            if (!mem_rd_en) begin
               state_in = S_IDLE;
            end
         end

         // list every entry, one beat a cycle
         S_DUMP: begin
            mem_rd_en = (iss_ff < count_ff);
            if (mem_rd_en) begin
               iss_in = iss_ff + ONE_C;
            end
            pend_in = mem_rd_en;
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_rec_in    = mem_rd_data;
               rsp_last_in   = at_last;
               if (at_last) begin
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = rsp_count_ff;
      if (rsp_strobe_in) begin
         rsp_count_in = ENTRY_W'(count_in);
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      req_ff        <= req_in;
      iss_ff        <= iss_in;
      pidx_ff       <= pidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_rec    = rsp_rec_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: rtl/core/keyed_record_table.sv
// Table-full and empty-table requests answer in the cycle after start, unused op codes give no beat;
// a lookup reads entries in order from position 0 and answers on a key hit or after the last entry.
// Delete then moves the tail up behind the hit, one entry a cycle.
// Dump gives one beat a cycle. Rate is set by the one read port of the record memory,
// and for lookups also by the single key compare; the receiver cannot stall.
// Reset empties the table (count to zero); memory contents are not cleared.
module keyed_record_table #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_record_key,
   input  logic [63:0]        req_name_text,
   input  logic [15:0]        req_party_size,
   input  logic [63:0]        req_time_head,
   input  logic [7:0]         req_time_tail,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_key,
   output logic [63:0]        rsp_out_name,
   output logic [15:0]        rsp_out_party_size,
   output logic [63:0]        rsp_out_time_head,
   output logic [7:0]         rsp_out_time_tail,
   output logic [5:0]         rsp_entry_count,
   output logic               rsp_last_result
);
   import krt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   record_type         req_rec;
   record_type         wr_data;
   record_type         rd_data;
   record_type         rsp_rec;
   status_type         status;
   logic               wr_en;
   logic               rd_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;

   // pack the request beat
   always_comb begin
      req_rec.key       = req_record_key;
      req_rec.name      = req_name_text;
      req_rec.party     = req_party_size;
      req_rec.time_head = req_time_head;
      req_rec.time_tail = req_time_tail;
   end

   krt_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_operation),
      .req_rec     (req_rec),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (status),
      .rsp_rec     (rsp_rec),
      .rsp_count   (rsp_entry_count),
      .rsp_last    (rsp_last_result)
   );

   krt_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // unpack the result beat
   assign rsp_status         = status;
   assign rsp_out_key        = rsp_rec.key;
   assign rsp_out_name       = rsp_rec.name;
   assign rsp_out_party_size = rsp_rec.party;
   assign rsp_out_time_head  = rsp_rec.time_head;
   assign rsp_out_time_tail  = rsp_rec.time_tail;

endmodule

// File: rtl/core/krt_checker.sv
// Port-level checks for the keyed record table, bound to the top level.
`include "keyed_record_table_defines.svh"

module krt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_out_key,
   input logic [63:0]        rsp_out_name,
   input logic [15:0]        rsp_out_party_size,
   input logic               rsp_last_result
);
   import krt_pkg::*;

   // a dump streams without gaps until its last beat
   `KRT_ASSERT_NEXT(a_dump_contiguous, rsp_strobe && !rsp_last_result, rsp_strobe, "dump stream broke before last beat")

   // only a dump gives non-final beats, and it is busy meanwhile
   `KRT_ASSERT_NOW(a_mid_beat_ok, rsp_strobe && !rsp_last_result, busy && (rsp_status == ST_OK), "non-final beat outside a dump")

   // failed requests return an empty record
   `KRT_ASSERT_NOW(a_fail_zero, rsp_strobe && (rsp_status != ST_OK), (rsp_out_key == 0) && (rsp_out_name == 0) && (rsp_out_party_size == 0), "failed request returned record data")

   // the block only goes busy on a start
   `KRT_ASSERT_NOW(a_busy_from_start, busy && !$past(busy), $past(start), "busy rose without a start")

endmodule

bind keyed_record_table krt_checker u_krt_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_out_key        (rsp_out_key),
   .rsp_out_name       (rsp_out_name),
   .rsp_out_party_size (rsp_out_party_size),
   .rsp_last_result    (rsp_last_result)
);

// File: bench/keyed_record_table_tb.sv
// Self-checking testbench for keyed_record_table: queued requests, predicted replies, checker.
`timescale 1ns / 100ps

module keyed_record_table_tb;
   import krt_pkg::*;

   localparam int TABLE_DEPTH   = 32;
   localparam int KEY_POOL_SIZE = 40;
   localparam int RANDOM_ITEMS  = 290;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int TAIL_CYCLES   = 80;
   localparam int REPORT_LIMIT  = 10;

   // operation codes the block ignores
   localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
   localparam logic [2:0] LAST_UNUSED_OP  = 3'd7;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic [2:0]  op;
      record_type  rec;
      int unsigned hold_off;
   } table_request;

   typedef struct {
      status_type status;
      record_type rec;
      logic [5:0] count;
      logic       last;
   } table_reply;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0]         req_operation  = '0;
   logic signed [31:0] req_record_key = '0;
   logic [63:0]        req_name_text  = '0;
   logic [15:0]        req_party_size = '0;
   logic [63:0]        req_time_head  = '0;
   logic [7:0]         req_time_tail  = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_out_key;
   logic [63:0]        rsp_out_name;
   logic [15:0]        rsp_out_party_size;
   logic [63:0]        rsp_out_time_head;
   logic [7:0]         rsp_out_time_tail;
   logic [5:0]         rsp_entry_count;
   logic               rsp_last_result;

   keyed_record_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_record_key     (req_record_key),
      .req_name_text      (req_name_text),
      .req_party_size     (req_party_size),
      .req_time_head      (req_time_head),
      .req_time_tail      (req_time_tail),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_name       (rsp_out_name),
      .rsp_out_party_size (rsp_out_party_size),
      .rsp_out_time_head  (rsp_out_time_head),
      .rsp_out_time_tail  (rsp_out_time_tail),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_last_result    (rsp_last_result)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   table_request request_queue[$];
   table_reply   awaited_replies[$];
   record_type   booking_image[$];

   table_request in_flight;
   table_request staged_item;
   logic         staged = 1'b0;
   int unsigned  idle_left = 0;
   logic         next_start;
   table_reply   checked_reply;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           random_done = 0;
   logic         eager = 1'b0;

   logic signed [31:0] key_pool[KEY_POOL_SIZE];
   int                 pool_order[KEY_POOL_SIZE];

   // Booking table predictor ----------------------------------------------

   function automatic void await_reply(status_type status, record_type rec, logic last);
      table_reply r;
      r.status = status;
      r.rec    = rec;
      r.count  = 6'(booking_image.size());
      r.last   = last;
      awaited_replies.push_back(r);
   endfunction

   function automatic void predict_replies(table_request req);
      int         hit;
      record_type gone;
      hit = -1;
      foreach (booking_image[i])
         if (hit < 0 && booking_image[i].key == req.rec.key) hit = i;
      case (req.op)
         OP_INSERT: begin
            if (booking_image.size() >= TABLE_DEPTH) begin
               // full wins over duplicate
               await_reply(ST_FULL, '0, 1'b1);
            end else if (hit >= 0) begin
               await_reply(ST_DUP, '0, 1'b1);
            end else begin
               booking_image.push_back(req.rec);
               await_reply(ST_OK, req.rec, 1'b1);
            end
         end
         OP_SEARCH: begin
            if (hit >= 0) await_reply(ST_OK, booking_image[hit], 1'b1);
            else await_reply(ST_MISS, '0, 1'b1);
         end
         OP_UPDATE: begin
            if (hit >= 0) begin
               booking_image[hit] = req.rec;
               await_reply(ST_OK, booking_image[hit], 1'b1);
            end else begin
               await_reply(ST_MISS, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               gone = booking_image[hit];
               booking_image.delete(hit);
               await_reply(ST_OK, gone, 1'b1);
            end else begin
               await_reply(ST_MISS, '0, 1'b1);
            end
         end
         OP_DUMP: begin
            // empty table still answers with one zeroed beat
            if (booking_image.size() == 0) await_reply(ST_OK, '0, 1'b1);
            foreach (booking_image[i])
               await_reply(ST_OK, booking_image[i], i == booking_image.size() - 1);
         end
         default: ;
      endcase
   endfunction

   // Request driver: one beat offered at a time, idle gap drawn per item ---

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            predict_replies(in_flight);
         next_start = start && busy;
         if (!next_start) begin
            if (!staged && request_queue.size() != 0) begin
               staged_item = request_queue.pop_front();
               staged      = 1'b1;
               idle_left   = staged_item.hold_off;
            end
            if (staged && idle_left == 0) begin
               in_flight = staged_item;
               staged    = 1'b0;
               req_operation  <= in_flight.op;
               req_record_key <= in_flight.rec.key;
               req_name_text  <= in_flight.rec.name;
               req_party_size <= in_flight.rec.party;
               req_time_head  <= in_flight.rec.time_head;
               req_time_tail  <= in_flight.rec.time_tail;
               next_start = 1'b1;
            end else if (staged) begin
               idle_left--;
            end
         end
         start <= next_start;
      end
   end

   // Reply checker --------------------------------------------------------

   task automatic note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got)
         note_failure($sformatf("%s expected %h, got %h", label, want, got));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            note_failure($sformatf("beat with nothing pending, key %h", rsp_out_key));
         end else begin
            checked_reply = awaited_replies.pop_front();
            compare_field("status", 64'(checked_reply.status), 64'(rsp_status));
            compare_field("key", 64'(checked_reply.rec.key), 64'(rsp_out_key));
            compare_field("name", checked_reply.rec.name, rsp_out_name);
            compare_field("party", 64'(checked_reply.rec.party), 64'(rsp_out_party_size));
            compare_field("time_head", checked_reply.rec.time_head, rsp_out_time_head);
            compare_field("time_tail", 64'(checked_reply.rec.time_tail),
                          64'(rsp_out_time_tail));
            compare_field("entry_count", 64'(checked_reply.count), 64'(rsp_entry_count));
            compare_field("last", 64'(checked_reply.last), 64'(rsp_last_result));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keyed_record_table_tb: errors");
         $finish;
      end
   end

   // Stimulus helpers -----------------------------------------------------

   function automatic record_type make_record(logic signed [31:0] key, logic [63:0] name,
                                              logic [15:0] party, logic [63:0] time_head,
                                              logic [7:0] time_tail);
      record_type rec;
      rec.key       = key;
      rec.name      = name;
      rec.party     = party;
      rec.time_head = time_head;
      rec.time_tail = time_tail;
      return rec;
   endfunction

   task automatic queue_exact(logic [2:0] op, record_type rec);
      table_request req;
      req.op       = op;
      req.rec      = rec;
      req.hold_off = eager ? 0 : $urandom_range(0, 8);
      request_queue.push_back(req);
      if (op <= OP_DUMP) random_done++;
   endtask

   // random payload; party size leans toward its extremes
   task automatic queue_request(logic [2:0] op, logic signed [31:0] key);
      logic [15:0] party;
      int          pick;
      pick  = $urandom_range(0, 9);
      party = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      queue_exact(op, make_record(key, {$urandom, $urandom}, party,
                                  {$urandom, $urandom}, 8'($urandom)));
   endtask

   task automatic shuffle_pool_order();
      int j;
      int held;
      foreach (pool_order[i]) pool_order[i] = i;
      for (int i = KEY_POOL_SIZE - 1; i > 0; i--) begin
         j             = $urandom_range(0, i);
         held          = pool_order[i];
         pool_order[i] = pool_order[j];
         pool_order[j] = held;
      end
   endtask

   // wait until every queued beat went out and every reply came back
   task automatic settle();
      while (request_queue.size() != 0 || staged || start || awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   // Stimulus -------------------------------------------------------------

   initial begin : stimulus
      int  phase;
      int  len;
      int  pick;
      logic fresh;
      logic signed [31:0] key;

      // key pool: the extremes, zero and minus one, then distinct random keys
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < KEY_POOL_SIZE; i++) begin
         fresh = 1'b0;
         while (!fresh) begin
            key   = $urandom;
            fresh = 1'b1;
            for (int k = 0; k < i; k++)
               if (key_pool[k] == key) fresh = 1'b0;
         end
         key_pool[i] = key;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, field extremes, every operation, ignored codes
      queue_exact(OP_DUMP, make_record('0, '0, '0, '0, '0));
      queue_request(OP_SEARCH, 32'sd0);
      queue_request(OP_UPDATE, KEY_MIN);
      queue_request(OP_DELETE, KEY_MAX);
      queue_exact(OP_INSERT, make_record(KEY_MIN, '1, '1, '1, '1));
      queue_exact(OP_INSERT, make_record(KEY_MAX, '0, '0, '0, '0));
      queue_exact(OP_INSERT, make_record(32'sd0, 64'h5555_5555_5555_5555, 16'h5555,
                                         64'hAAAA_AAAA_AAAA_AAAA, 8'hAA));
      queue_exact(OP_INSERT, make_record(-32'sd1, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA,
                                         64'h5555_5555_5555_5555, 8'h55));
      queue_request(OP_INSERT, 32'sd0);
      queue_request(OP_SEARCH, KEY_MIN);
      queue_request(OP_SEARCH, -32'sd1);
      queue_exact(OP_UPDATE, make_record(KEY_MAX, '1, '1, '1, '1));
      queue_request(OP_UPDATE, -32'sd1);
      queue_request(OP_DUMP, 32'sd0);
      queue_request(OP_DELETE, 32'sd0);
      queue_request(OP_DELETE, -32'sd1);
      queue_request(OP_DELETE, 32'sd0);
      queue_request(OP_DELETE, KEY_MIN);
      for (int u = FIRST_UNUSED_OP; u <= LAST_UNUSED_OP; u++)
         queue_request(3'(u), KEY_MAX);
      queue_request(OP_DUMP, 32'sd0);
      queue_request(OP_SEARCH, KEY_MAX);
      queue_request(OP_DELETE, KEY_MAX);
      queue_request(OP_DUMP, 32'sd0);
      settle();

      // random phases: fill to full, mixed traffic, drain the pool keys
      random_done = 0;
      phase       = 0;
      while (random_done < RANDOM_ITEMS) begin
         eager = ($urandom_range(0, 2) == 0);
         case (phase % 3)
            0: begin
               // every pool key once, so the table ends full; some repeats hit full/dup
               shuffle_pool_order();
               foreach (pool_order[i]) begin
                  queue_request(OP_INSERT, key_pool[pool_order[i]]);
                  if ($urandom_range(0, 3) == 0)
                     queue_request($urandom_range(0, 1) ? OP_INSERT : OP_SEARCH,
                                   key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]);
               end
               queue_request(OP_DUMP, 32'sd0);
            end
            1: begin
               len = $urandom_range(30, 60);
               repeat (len) begin
                  pick = $urandom_range(0, 99);
                  key  = ($urandom_range(0, 9) == 0) ? $urandom
                                                     : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                  if (pick < 30)      queue_request(OP_INSERT, key);
                  else if (pick < 50) queue_request(OP_SEARCH, key);
                  else if (pick < 65) queue_request(OP_UPDATE, key);
                  else if (pick < 85) queue_request(OP_DELETE, key);
                  else if (pick < 92) queue_request(OP_DUMP, key);
                  else if (pick < 97) queue_request(OP_SEARCH, $urandom);
                  else queue_request(3'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP)), key);
               end
            end
            default: begin
               // delete every pool key, so only keys from outside the pool can remain
               shuffle_pool_order();
               foreach (pool_order[i]) begin
                  queue_request(OP_DELETE, key_pool[pool_order[i]]);
                  if ($urandom_range(0, 4) == 0)
                     queue_request(OP_SEARCH, key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]);
               end
               queue_request(OP_DUMP, 32'sd0);
            end
         endcase
         phase++;
         // after the first phase, and at random later, the sender waits for every reply
         if (phase == 1 || $urandom_range(0, 1) == 1) settle();
      end

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaited_replies.size() == 0)
         $display("keyed_record_table_tb: clean");
      else
         $display("keyed_record_table_tb: errors");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/krt_pkg.sv
rtl/core/krt_store.sv
rtl/core/krt_seq.sv
rtl/core/keyed_record_table.sv
rtl/core/krt_checker.sv
bench/keyed_record_table_tb.sv
